@@ rtl/inverse_error_function_approx_assert.svh @@
// Assertion macros for the inverse error function pipeline.
// Used by inverse_error_function_approx; relies on clk and arst_n in scope.
`ifndef INVERSE_ERROR_FUNCTION_APPROX_ASSERT_SVH
`define INVERSE_ERROR_FUNCTION_APPROX_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ERFINV_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("erfinv assertion failed");

// signal never high outside reset
`define ERFINV_ASSERT_NEVER(lbl, a) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(a)) \
		else $error("erfinv assertion failed");

`endif

@@ rtl/erfinv_pkg.sv @@
// Shared constants and types for the inverse error function pipeline.
// No dependencies.
package erfinv_pkg;
	localparam int IN_FRAC_BITS  = 15;
	localparam int OUT_FRAC_BITS = 12;
	localparam int LOG_STEPS     = 32;
	localparam int SQ_STEPS      = 32;
	// register count from accepted transaction to done
	localparam int LATENCY       = 3 + LOG_STEPS + 5 + SQ_STEPS + 1 + SQ_STEPS + 1;

	localparam logic [31:0] LN2_Q32   = 32'd2977044472;
	localparam logic [26:0] C_Q24     = 27'd72657874;
	localparam logic [26:0] INV_A_Q24 = 27'd114130721;

	localparam logic signed [15:0] RES_MAX = 16'sh7FFF;
	localparam logic signed [15:0] RES_MIN = 16'sh8000;

	typedef struct packed {
		logic        valid;
		logic        neg;
		logic        dom;
		logic        kneg;
		logic [4:0]  n;
		logic [27:0] kmag;
	} side_t;
endpackage

@@ rtl/erfinv_log_cell.sv @@
// One squaring step of the log2 fraction extraction.
// Depends on erfinv_pkg.
module erfinv_log_cell import erfinv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] m_in,
	input  logic [31:0] frac_in,
	input  side_t       side_in,
	output logic [31:0] m_q,
	output logic [31:0] frac_q,
	output side_t       side_q
);
	logic [63:0] sq;
	logic [32:0] sh;

	assign sq = 64'(m_in) * 64'(m_in);
	assign sh = sq[63:31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else begin
			side_q <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		m_q    <= sh[32] ? sh[32:1] : sh[31:0];
		frac_q <= {frac_in[30:0], sh[32]};
	end
endmodule

@@ rtl/erfinv_sqrt_cell.sv @@
// One digit step of the restoring integer square root.
// Depends on erfinv_pkg.
module erfinv_sqrt_cell import erfinv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [4:0]  step,
	input  logic [63:0] v_in,
	input  logic [63:0] res_in,
	input  side_t       side_in,
	output logic [63:0] v_q,
	output logic [63:0] res_q,
	output side_t       side_q
);
	logic [63:0] bitv;
	logic [63:0] trial;
	logic [6:0]  pos;

	assign pos   = 7'd62 - {1'b0, step, 1'b0};
	assign bitv  = 64'd1 << pos;
	assign trial = res_in + bitv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else begin
			side_q <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		if (v_in >= trial) begin
			v_q   <= v_in - trial;
			res_q <= (res_in >> 1) + bitv;
		end else begin
			v_q   <= v_in;
			res_q <= res_in >> 1;
		end
	end
endmodule

@@ rtl/inverse_error_function_approx.sv @@
// Inverse error function (Winitzki form, a = 0.147), Q1.15 in, Q4.12 out.
// Depends on erfinv_pkg, erfinv_log_cell, erfinv_sqrt_cell and the assert header.
//
// Fully pipelined: one transaction may start every cycle (busy is always low) and its
// result appears on result_value/domain_error with done high for one cycle. The
// depth is mostly set by the 32-cell log2 squaring chain and the two 32-cell
// square-root chains. The receiver cannot stall; results must be taken.
`include "inverse_error_function_approx_assert.svh"
module inverse_error_function_approx import erfinv_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] arg_value,
	output logic               done,
	output logic signed [15:0] result_value,
	output logic               domain_error
);
	assign busy = 1'b0;

	// input stage
	logic [16:0] mag_in;
	side_t       sd_s1, sd_s2, sd_s3;
	logic [15:0] mag_s1;
	logic [30:0] u_s2;
	logic [31:0] m_s3;
	logic [31:0] mag_sq;

	assign mag_in = arg_value[15] ? (17'd0 - {arg_value[15], arg_value})
		: {1'b0, arg_value};
	assign mag_sq = 32'(mag_s1) * 32'(mag_s1);

	// leading one of u
	logic [4:0]  lead;
	always_comb begin
		lead = '0;
		for (int i = 0; i < 31; i++) begin
			if (u_s2[i]) lead = 5'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sd_s1 <= '0;
			sd_s2 <= '0;
			sd_s3 <= '0;
		end else begin
			sd_s1 <= '{valid: start, neg: arg_value[15],
				dom: (mag_in >= 17'(1 << IN_FRAC_BITS)), kneg: 1'b0, n: '0, kmag: '0};
			sd_s2 <= sd_s1;
			sd_s3 <= '{valid: sd_s2.valid, neg: sd_s2.neg, dom: sd_s2.dom,
				kneg: sd_s2.kneg, n: lead, kmag: sd_s2.kmag};
		end
	end

	always_ff @(posedge clk) begin
		mag_s1 <= mag_in[15:0];
		u_s2   <= 31'((64'd1 << (2 * IN_FRAC_BITS)) - 64'(mag_sq));
		m_s3   <= 32'(u_s2) << (5'd31 - lead);
	end

	// log2 chain
	logic [31:0] lm [0:LOG_STEPS];
	logic [31:0] lf [0:LOG_STEPS];
	side_t       ls [0:LOG_STEPS];
	assign lm[0] = m_s3;
	assign lf[0] = '0;
	assign ls[0] = sd_s3;

	for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
		erfinv_log_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.m_in(lm[g]), .frac_in(lf[g]), .side_in(ls[g]),
			.m_q(lm[g+1]), .frac_q(lf[g+1]), .side_q(ls[g+1])
		);
	end

	// t, p, k, products, radicand
	logic [36:0] whole;
	logic [36:0] tval;
	logic [28:0] tq_s4;
	logic [28:0] p_s5, p_s6;
	logic [60:0] pprod;
	logic [28:0] half;
	logic        kneg_nxt;
	logic [27:0] kmag_nxt;
	logic [33:0] k2_s7, hq_s7;
	logic [55:0] ksq, hprod;
	logic [63:0] v_s8;
	side_t       sd_s4, sd_s5, sd_s6, sd_s7, sd_s8;

	assign whole = {5'd30 - ls[LOG_STEPS].n, 32'd0};
	assign tval  = (whole >= 37'(lf[LOG_STEPS])) ? whole - 37'(lf[LOG_STEPS]) : '0;
	assign pprod = 61'(tq_s4) * 61'(LN2_Q32);
	assign half  = 29'((30'(p_s5) + 30'd1) >> 1);
	assign kneg_nxt = half > 29'(C_Q24);
	assign kmag_nxt = kneg_nxt ? 28'(half - 29'(C_Q24)) : 28'(29'(C_Q24) - half);
	assign ksq   = 56'(sd_s6.kmag) * 56'(sd_s6.kmag);
	assign hprod = 56'(p_s6) * 56'(INV_A_Q24);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sd_s4 <= '0;
			sd_s5 <= '0;
			sd_s6 <= '0;
			sd_s7 <= '0;
			sd_s8 <= '0;
		end else begin
			sd_s4 <= ls[LOG_STEPS];
			sd_s5 <= sd_s4;
			sd_s6 <= '{valid: sd_s5.valid, neg: sd_s5.neg, dom: sd_s5.dom,
				kneg: kneg_nxt, n: sd_s5.n, kmag: kmag_nxt};
			sd_s7 <= sd_s6;
			sd_s8 <= sd_s7;
		end
	end

	always_ff @(posedge clk) begin
		tq_s4 <= tval[36:8];
		p_s5  <= 29'((62'(pprod) + 62'(64'd1 << 31)) >> 32);
		p_s6  <= p_s5;
		k2_s7 <= 34'((57'(ksq) + 57'(1 << 23)) >> 24);
		hq_s7 <= 34'((57'(hprod) + 57'(1 << 23)) >> 24);
		v_s8  <= 64'(35'(k2_s7) + 35'(hq_s7)) << 24;
	end

	// first square root
	logic [63:0] av [0:SQ_STEPS];
	logic [63:0] ar [0:SQ_STEPS];
	side_t       as [0:SQ_STEPS];
	assign av[0] = v_s8;
	assign ar[0] = '0;
	assign as[0] = sd_s8;

	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqa
		erfinv_sqrt_cell u_cell (
			.clk(clk), .arst_n(arst_n), .step(5'(g)),
			.v_in(av[g]), .res_in(ar[g]), .side_in(as[g]),
			.v_q(av[g+1]), .res_q(ar[g+1]), .side_q(as[g+1])
		);
	end

	// inner = S - k, clamped
	logic [31:0] sroot;
	logic [31:0] kext;
	logic [31:0] inner;
	logic [63:0] v_s9;
	side_t       sd_s9;

	assign sroot = ar[SQ_STEPS][31:0];
	assign kext  = 32'(as[SQ_STEPS].kmag);
	assign inner = as[SQ_STEPS].kneg ? sroot + kext
		: ((sroot > kext) ? sroot - kext : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sd_s9 <= '0;
		end else begin
			sd_s9 <= as[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		v_s9 <= {inner, 32'd0};
	end

	// second square root
	logic [63:0] bv [0:SQ_STEPS];
	logic [63:0] br [0:SQ_STEPS];
	side_t       bs [0:SQ_STEPS];
	assign bv[0] = v_s9;
	assign br[0] = '0;
	assign bs[0] = sd_s9;

	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqb
		erfinv_sqrt_cell u_cell (
			.clk(clk), .arst_n(arst_n), .step(5'(g)),
			.v_in(bv[g]), .res_in(br[g]), .side_in(bs[g]),
			.v_q(bv[g+1]), .res_q(br[g+1]), .side_q(bs[g+1])
		);
	end

	// round, saturate, sign
	localparam int SH = 28 - OUT_FRAC_BITS;
	logic [63:0] rnd;
	logic [15:0] rmag_pos;
	logic [16:0] rmag_neg;
	side_t       fs;
	logic signed [15:0] res_nxt;

	assign fs  = bs[SQ_STEPS];
	assign rnd = (br[SQ_STEPS] + (64'd1 << (SH - 1))) >> SH;
	assign rmag_pos = (rnd > 64'd32767) ? 16'd32767 : rnd[15:0];
	assign rmag_neg = (rnd > 64'd32768) ? 17'd32768 : rnd[16:0];

	always_comb begin
		if (fs.dom) begin
			res_nxt = fs.neg ? RES_MIN : RES_MAX;
		end else if (fs.neg) begin
			res_nxt = 16'(17'd0 - rmag_neg);
		end else begin
			res_nxt = rmag_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done         <= 1'b0;
			domain_error <= 1'b0;
		end else begin
			done         <= fs.valid;
			domain_error <= fs.valid & fs.dom;
		end
	end

	always_ff @(posedge clk) begin
		result_value <= res_nxt;
	end

	`ERFINV_ASSERT_IMP(a_dom_needs_done, domain_error, done)
	`ERFINV_ASSERT_IMP(a_dom_saturates, done && domain_error,
		result_value == RES_MAX || result_value == RES_MIN)
	`ERFINV_ASSERT_IMP(a_latency, $past(arst_n, LATENCY) && $past(start, LATENCY), done)
	`ERFINV_ASSERT_IMP(a_no_spurious, done && $past(arst_n, LATENCY), $past(start, LATENCY))
	`ERFINV_ASSERT_NEVER(a_never_busy, busy)
endmodule

@@ sim/inverse_error_function_approx_tb.sv @@
`timescale 1ns / 100ps
// Testbench for inverse_error_function_approx: directed table plus random arguments.
// Depends on erfinv_pkg and the RTL; results are checked against a local fixed-point predictor.
module inverse_error_function_approx_tb;
	import erfinv_pkg::*;

	typedef struct {
		logic signed [15:0] value;
		logic               dom;
	} erfinv_res_t;

	typedef struct {
		logic signed [15:0] arg;
		bit                 typed;
		logic signed [15:0] value;
		logic               dom;
	} dir_row_t;

	localparam logic [63:0] LN2_C   = 64'd2977044472;
	localparam logic [63:0] C_K     = 64'd72657874;
	localparam logic [63:0] INV_A_C = 64'd114130721;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [15:0] arg_value;
	logic               done;
	logic signed [15:0] result_value;
	logic               domain_error;

	erfinv_res_t pending_results[$];
	int          mismatches;
	int          unexpected;
	int          accepted;
	int          checked;
	int          dom_seen;

	inverse_error_function_approx DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.arg_value(arg_value), .done(done), .result_value(result_value),
		.domain_error(domain_error)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	function automatic logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// -log2(u / 2^30) in Q32, via repeated squaring of the normalized mantissa
	function automatic logic [63:0] neg_log2_q32(logic [63:0] u);
		int          n;
		logic [63:0] m;
		logic [63:0] frac;
		logic [63:0] whole;
		n = 63;
		frac = 0;
		while (n > 0 && u[n] == 1'b0) n--;
		if (n >= 31) m = u >> (n - 31);
		else m = u << (31 - n);
		for (int i = 0; i < 32; i++) begin
			m = (m * m) >> 31;
			if (m >= (64'd1 << 32)) begin
				m = m >> 1;
				frac[31 - i] = 1'b1;
			end
		end
		if (n > 2 * IN_FRAC_BITS) return 0;
		whole = 64'(2 * IN_FRAC_BITS - n) << 32;
		return (whole >= frac) ? whole - frac : 64'd0;
	endfunction

	function automatic erfinv_res_t erfinv_predict(logic signed [15:0] y);
		erfinv_res_t res;
		logic        neg;
		logic [63:0] mag, one, u, t, p, half, kmag, k2, hq, s, inner, x, r;
		logic        kneg;
		neg = y[15];
		mag = neg ? (64'h10000 - 64'({1'b0, y[15:0]})) : 64'(y[15:0]);
		one = 64'd1 << IN_FRAC_BITS;
		if (mag >= one) begin
			res.value = neg ? RES_MIN : RES_MAX;
			res.dom = 1'b1;
			return res;
		end
		u = one * one - mag * mag;
		t = neg_log2_q32(u);
		p = ((t >> 8) * LN2_C + (64'd1 << 31)) >> 32;
		half = (p + 1) >> 1;
		if (half > C_K) begin
			kneg = 1'b1;
			kmag = half - C_K;
		end else begin
			kneg = 1'b0;
			kmag = C_K - half;
		end
		k2 = (kmag * kmag + (64'd1 << 23)) >> 24;
		hq = (p * INV_A_C + (64'd1 << 23)) >> 24;
		s = isqrt((k2 + hq) << 24);
		if (kneg) inner = s + kmag;
		else inner = (s > kmag) ? s - kmag : 64'd0;
		x = isqrt(inner << 32);
		r = (x + (64'd1 << (27 - OUT_FRAC_BITS))) >> (28 - OUT_FRAC_BITS);
		if (neg) begin
			if (r > 64'd32768) r = 64'd32768;
			res.value = 16'(64'h10000 - r);
		end else begin
			if (r > 64'd32767) r = 64'd32767;
			res.value = 16'(r);
		end
		res.dom = 1'b0;
		return res;
	endfunction

	// expectations enter at acceptance, results are checked when done strobes
	always @(posedge clk) begin
		erfinv_res_t want;
		if (arst_n && start && !busy) begin
			pending_results.push_back(erfinv_predict(arg_value));
			accepted++;
		end
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				unexpected++;
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result %0d/%0b with no transaction pending", $realtime,
						result_value, domain_error);
			end else begin
				want = pending_results.pop_front();
				checked++;
				if (domain_error) dom_seen++;
				if (result_value !== want.value || domain_error !== want.dom) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch value exp %0d got %0d, domain exp %0b got %0b",
							$realtime, want.value, result_value, want.dom, domain_error);
				end
			end
		end
	end

	task automatic send_arg(logic signed [15:0] a, int idle_pct);
		while ($urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		arg_value <= a;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] random_arg();
		int      pick;
		int      m;
		pick = $urandom_range(9, 0);
		if (pick < 5) return 16'($urandom());
		if (pick < 7) m = $urandom_range(32767, 32000);
		else if (pick < 9) m = $urandom_range(64, 0);
		else m = $urandom_range(32767, 0);
		return ($urandom_range(1, 0) != 0) ? 16'(-m) : 16'(m);
	endfunction

	task automatic drain(int extra);
		start <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0) @(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	initial begin
		dir_row_t dir_rows[$];
		int       idle_pct;
		dir_rows = '{
			'{16'sh8000, 1'b1, RES_MIN, 1'b1},
			'{16'sh0000, 1'b1, 16'sh0000, 1'b0},
			'{16'sh7FFF, 1'b0, 16'sh0, 1'b0},
			'{16'sh8001, 1'b0, 16'sh0, 1'b0},
			'{16'sh0001, 1'b0, 16'sh0, 1'b0},
			'{16'shFFFF, 1'b0, 16'sh0, 1'b0},
			'{16'sh4000, 1'b0, 16'sh0, 1'b0},
			'{16'shC000, 1'b0, 16'sh0, 1'b0},
			'{16'sh7FFE, 1'b0, 16'sh0, 1'b0},
			'{16'sh8002, 1'b0, 16'sh0, 1'b0},
			'{16'sh7000, 1'b0, 16'sh0, 1'b0},
			'{16'sh0100, 1'b0, 16'sh0, 1'b0},
			'{16'sh8000, 1'b1, RES_MIN, 1'b1},
			'{16'sh5555, 1'b0, 16'sh0, 1'b0},
			'{16'shAAAA, 1'b0, 16'sh0, 1'b0},
			'{16'sh7F00, 1'b0, 16'sh0, 1'b0}
		};
		mismatches = 0;
		unexpected = 0;
		accepted = 0;
		checked = 0;
		dom_seen = 0;
		arst_n = 1'b0;
		start = 1'b0;
		arg_value = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			send_arg(dir_rows[i].arg, 0);
			// typed-in rows double-check the predictor on obvious values
			if (dir_rows[i].typed) begin
				erfinv_res_t p;
				p = erfinv_predict(dir_rows[i].arg);
				if (p.value !== dir_rows[i].value || p.dom !== dir_rows[i].dom) begin
					mismatches++;
					if (mismatches <= 10)
						$display("table row %0d: predictor %0d/%0b, table %0d/%0b", i,
							p.value, p.dom, dir_rows[i].value, dir_rows[i].dom);
				end
			end
		end
		drain(0);

		// phases: back-to-back, sender mostly idle, moderate idling, back-to-back again
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: idle_pct = 0;
				1: idle_pct = 59;
				2: idle_pct = 25;
				default: idle_pct = 0;
			endcase
			for (int i = 0; i < 350; i++) begin
				send_arg(random_arg(), idle_pct);
				if (ph == 1 && i == 175) drain(0);
			end
		end
		drain(LATENCY + 10);

		$display("Ran %0d transactions (%0d checked, %0d domain errors), idle mixes 0/59/25 pct.",
			accepted, checked, dom_seen);
		$display("Mismatches: %0d, results with nothing pending: %0d", mismatches, unexpected);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("inverse_error_function_approx_tb OK");
		end else begin
			$display("inverse_error_function_approx_tb NOT OK");
		end
		$finish;
	end

	initial begin
		#200000;
		$display("Timeout");
		$display("inverse_error_function_approx_tb NOT OK");
		$finish;
	end
endmodule
